### src/buddy_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// buddy block allocator assertion macros
// concurrent checks written once, used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants and types of the buddy block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int POOL_ORDER_DEF = 16;
    localparam int MIN_ORDER_DEF  = 5;

    localparam int ADDR_W = 16;
    localparam int SIZE_W = 16;
    localparam int ORD_W  = 5;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [1:0]        t_status;

    // op codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // status codes
    localparam t_status STAT_OK      = 2'd0;
    localparam t_status STAT_NOFIT   = 2'd1;
    localparam t_status STAT_BADFREE = 2'd2;

endpackage

`default_nettype wire

### src/bba_if.sv
// ----------------------------------------------------------------------------
// bba request and response channels
// valid/ready channels carrying one item each
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
    logic          valid;
    logic          ready;
    logic          op;
    bba_pkg::t_size req_size;
    bba_pkg::t_addr free_addr;

    modport source (output valid, output op, output req_size, output free_addr,
                    input ready);
    modport sink   (input valid, input op, input req_size, input free_addr,
                    output ready);
endinterface

interface bba_rsp_if;
    logic             valid;
    logic             ready;
    bba_pkg::t_addr   result_addr;
    bba_pkg::t_status status;

    modport source (output valid, output result_addr, output status, input ready);
    modport sink   (input valid, input result_addr, input status, output ready);
endinterface

`default_nettype wire

### src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// one node-memory access per tree level on descent, split, merge and the
//   mask update back to the root; items rejected on decode skip the tree,
//   others may be rejected after the root or leaf read
// throughput: one item at a time; the next item is taken once the result has
//   gone into the output register
// reset: synchronous, active low; then a clearing pass over every node
//   during which no item is taken
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator #(
    parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    bba_req_if.sink     i_req,
    bba_rsp_if.source   o_rsp
);

    // tree geometry
    localparam int PO     = POOL_ORDER;
    localparam int LV     = POOL_ORDER - MIN_ORDER + 1;   // orders in the tree
    localparam int NODES  = (1 << LV) - 1;
    localparam int LEAVES = 1 << (LV - 1);
    localparam int NAW    = LV;
    localparam int LAW    = LV - 1;
    localparam int NW     = LV + 1;                       // free bit + order mask
    localparam int OW     = bba_pkg::ORD_W;
    localparam int LW     = OW + 1;                       // alloc flag + order

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A_ROOT = 4'd1;
    localparam logic [3:0] S_A_DESC = 4'd2;
    localparam logic [3:0] S_SPLIT  = 4'd3;
    localparam logic [3:0] S_ASC    = 4'd4;
    localparam logic [3:0] S_ASC_W  = 4'd5;
    localparam logic [3:0] S_F_LEAF = 4'd6;
    localparam logic [3:0] S_M_Z    = 4'd7;
    localparam logic [3:0] S_M_W    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    // node address of the order-lvl block at offset off (root is node 0)
    function automatic logic [NAW-1:0] node_addr(input logic [OW-1:0] lvl,
                                                 input logic [PO-1:0] off);
        logic [31:0] base;
        logic [31:0] idx;
        base = (32'd1 << (32'(POOL_ORDER) - 32'(lvl))) - 32'd1;
        idx  = 32'(off) >> lvl;
        return NAW'(base + idx);
    endfunction

    // mask bit standing for a free block of order o
    function automatic logic [LV-1:0] ord_bit(input logic [OW-1:0] o);
        return LV'(1) << (o - OW'(MIN_ORDER));
    endfunction

    // size of an order-lvl block as an offset step
    function automatic logic [PO-1:0] blk(input logic [OW-1:0] lvl);
        return PO'(1) << lvl;
    endfunction

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    logic [3:0]           r_state,    n_state;
    logic [OW-1:0]        r_lvl,      n_lvl;       // order of the current node
    logic [OW-1:0]        r_tgt,      n_tgt;       // order the request needs
    logic [OW-1:0]        r_found,    n_found;     // order of the block taken
    logic [PO-1:0]        r_off,      n_off;       // offset of the current node
    logic [LV-1:0]        r_mask,     n_mask;      // new mask of the current node
    bba_pkg::t_addr       r_res_addr, n_res_addr;
    bba_pkg::t_status     r_res_st,   n_res_st;
    logic                 r_out_valid;
    bba_pkg::t_addr       r_out_addr;
    bba_pkg::t_status     r_out_st;
    logic                 r_clr;
    logic [NAW-1:0]       r_clr_cnt;

    // ------------------------------------------------------------------------
    // memories: buddy tree nodes and per-minimum-block allocation records
    // ------------------------------------------------------------------------
    logic                 node_we;
    logic [NAW-1:0]       node_waddr;
    logic [NW-1:0]        node_wdata;
    logic [NAW-1:0]       node_raddr;
    logic [NW-1:0]        node_rd;
    logic                 leaf_we;
    logic [LAW-1:0]       leaf_waddr;
    logic [LW-1:0]        leaf_wdata;
    logic [LAW-1:0]       leaf_raddr;
    logic [LW-1:0]        leaf_rd;

    bba_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rd)
    );

    bba_ram #(.WIDTH(LW), .DEPTH(LEAVES)) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (leaf_wdata),
        .i_raddr (leaf_raddr),
        .o_rdata (leaf_rd)
    );

    logic          node_free;
    logic [LV-1:0] node_mask;
    logic          leaf_flag;
    logic [OW-1:0] leaf_order;

    assign node_free  = node_rd[LV];
    assign node_mask  = node_rd[LV-1:0];
    assign leaf_flag  = leaf_rd[OW];
    assign leaf_order = leaf_rd[OW-1:0];

    // ------------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------------
    logic [OW-1:0] size_bits;   // bit length of req_size
    logic [OW-1:0] need_ord;
    logic [31:0]   free_off;
    logic          free_bad;

    always_comb begin
        size_bits = '0;
        for (int i = 0; i < bba_pkg::SIZE_W; i++) begin
            if (i_req.req_size[i]) begin
                size_bits = OW'(i + 1);
            end
        end
        // the request plus one header byte, rounded up to a power of two, at least the minimum block
        need_ord = (size_bits < OW'(MIN_ORDER)) ? OW'(MIN_ORDER) : size_bits;
    end

    always_comb begin
        free_off = 32'(i_req.free_addr) - 32'd1;
        free_bad = (i_req.free_addr == '0)
                || ((free_off & ((32'd1 << MIN_ORDER) - 32'd1)) != 32'd0)
                || ((free_off >> POOL_ORDER) != 32'd0);
    end

    // smallest free order at or above the request, from the root mask
    logic          hit;
    logic [OW-1:0] hit_ord;

    always_comb begin
        hit     = 1'b0;
        hit_ord = '0;
        for (int i = 0; i < LV; i++) begin
            if (!hit && node_mask[i] && (OW'(i + MIN_ORDER) >= r_tgt)) begin
                hit     = 1'b1;
                hit_ord = OW'(i + MIN_ORDER);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    logic [OW-1:0] lvl_dn;      // one order down
    logic [OW-1:0] lvl_up;      // one order up
    logic [PO-1:0] desc_off;
    logic [PO-1:0] buddy_off;
    logic [PO-1:0] par_off;
    logic [LV-1:0] up_mask;
    logic          out_load;

    assign lvl_dn    = r_lvl - OW'(1);
    assign lvl_up    = r_lvl + OW'(1);
    assign buddy_off = r_off ^ blk(r_lvl);
    assign par_off   = r_off & ~blk(r_lvl);
    assign up_mask   = r_mask | node_mask;
    // take the lower child when it holds a free block of the chosen order
    assign desc_off  = ((node_mask & ord_bit(r_found)) != '0) ? r_off
                                                              : (r_off | blk(lvl_dn));

    assign i_req.ready = (r_state == S_IDLE) && !r_clr;

    always_comb begin
        n_state    = r_state;
        n_lvl      = r_lvl;
        n_tgt      = r_tgt;
        n_found    = r_found;
        n_off      = r_off;
        n_mask     = r_mask;
        n_res_addr = r_res_addr;
        n_res_st   = r_res_st;
        node_we    = 1'b0;
        node_waddr = '0;
        node_wdata = '0;
        node_raddr = '0;
        leaf_we    = 1'b0;
        leaf_waddr = '0;
        leaf_wdata = '0;
        leaf_raddr = '0;
        out_load   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid && !r_clr) begin
                    if (i_req.op == bba_pkg::OP_ALLOC) begin
                        if (need_ord > OW'(POOL_ORDER)) begin
                            n_res_addr = '0;
                            n_res_st   = bba_pkg::STAT_NOFIT;
                            n_state    = S_DONE;
                        end else begin
                            n_tgt      = need_ord;
                            node_raddr = '0;
                            n_state    = S_A_ROOT;
                        end
                    end else begin
                        if (free_bad) begin
                            n_res_addr = '0;
                            n_res_st   = bba_pkg::STAT_BADFREE;
                            n_state    = S_DONE;
                        end else begin
                            n_off      = free_off[PO-1:0];
                            leaf_raddr = LAW'(free_off >> MIN_ORDER);
                            n_state    = S_F_LEAF;
                        end
                    end
                end
            end
            S_A_ROOT: begin
                if (!hit) begin
                    n_res_addr = '0;
                    n_res_st   = bba_pkg::STAT_NOFIT;
                    n_state    = S_DONE;
                end else begin
                    n_found = hit_ord;
                    n_lvl   = OW'(POOL_ORDER);
                    n_off   = '0;
                    if (hit_ord == OW'(POOL_ORDER)) begin
                        n_state = S_SPLIT;
                    end else begin
                        node_raddr = node_addr(OW'(POOL_ORDER - 1), '0);
                        n_state    = S_A_DESC;
                    end
                end
            end
            S_A_DESC: begin
                n_lvl = lvl_dn;
                n_off = desc_off;
                if (lvl_dn == r_found) begin
                    n_state = S_SPLIT;
                end else begin
                    node_raddr = node_addr(lvl_dn - OW'(1), desc_off);
                end
            end
            S_SPLIT: begin
                node_we = 1'b1;
                if (r_lvl != r_tgt) begin
                    // upper half of the block becomes free
                    node_waddr = node_addr(lvl_dn, r_off | blk(lvl_dn));
                    node_wdata = {1'b1, ord_bit(lvl_dn)};
                    n_lvl      = lvl_dn;
                end else begin
                    node_waddr = node_addr(r_lvl, r_off);
                    node_wdata = '0;
                    leaf_we    = 1'b1;
                    leaf_waddr = LAW'(r_off >> MIN_ORDER);
                    leaf_wdata = {1'b1, r_tgt};
                    n_mask     = '0;
                    n_res_addr = bba_pkg::ADDR_W'(32'(r_off) + 32'd1);
                    n_res_st   = bba_pkg::STAT_OK;
                    n_state    = S_ASC;
                end
            end
            S_ASC: begin
                if (r_lvl == OW'(POOL_ORDER)) begin
                    n_state = S_DONE;
                end else begin
                    node_raddr = node_addr(r_lvl, buddy_off);
                    n_state    = S_ASC_W;
                end
            end
            S_ASC_W: begin
                // parent mask is the union of both children, parent not free
                node_we    = 1'b1;
                node_waddr = node_addr(lvl_up, par_off);
                node_wdata = {1'b0, up_mask};
                n_mask     = up_mask;
                n_lvl      = lvl_up;
                n_off      = par_off;
                if (lvl_up == OW'(POOL_ORDER)) begin
                    n_state = S_DONE;
                end else begin
                    node_raddr = node_addr(lvl_up, par_off ^ blk(lvl_up));
                end
            end
            S_F_LEAF: begin
                if (!leaf_flag) begin
                    n_res_addr = '0;
                    n_res_st   = bba_pkg::STAT_BADFREE;
                    n_state    = S_DONE;
                end else begin
                    leaf_we    = 1'b1;
                    leaf_waddr = LAW'(r_off >> MIN_ORDER);
                    leaf_wdata = {1'b0, leaf_order};
                    n_lvl      = leaf_order;
                    n_res_addr = '0;
                    n_res_st   = bba_pkg::STAT_OK;
                    n_state    = S_M_Z;
                end
            end
            S_M_Z: begin
                node_we = 1'b1;
                if (r_lvl == OW'(POOL_ORDER)) begin
                    node_waddr = '0;
                    node_wdata = {1'b1, ord_bit(r_lvl)};
                    n_mask     = ord_bit(r_lvl);
                    n_state    = S_ASC;
                end else begin
                    // node lies inside the merged block for now
                    node_waddr = node_addr(r_lvl, r_off);
                    node_wdata = '0;
                    node_raddr = node_addr(r_lvl, buddy_off);
                    n_state    = S_M_W;
                end
            end
            S_M_W: begin
                node_we = 1'b1;
                if (node_free) begin
                    node_waddr = node_addr(r_lvl, buddy_off);
                    node_wdata = '0;
                    n_off      = par_off;
                    n_lvl      = lvl_up;
                    n_state    = S_M_Z;
                end else begin
                    node_waddr = node_addr(r_lvl, r_off);
                    node_wdata = {1'b1, ord_bit(r_lvl)};
                    n_mask     = ord_bit(r_lvl);
                    n_state    = S_ASC;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // clearing pass after reset, only the root starts free
        if (r_clr) begin
            node_we    = 1'b1;
            node_waddr = r_clr_cnt;
            node_wdata = (r_clr_cnt == '0) ? {1'b1, ord_bit(OW'(POOL_ORDER))} : '0;
            leaf_we    = 1'b1;
            leaf_waddr = r_clr_cnt[LAW-1:0];
            leaf_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_clr       <= 1'b1;
            r_clr_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + NAW'(1);
                if (r_clr_cnt == NAW'(NODES - 1)) begin
                    r_clr <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl      <= n_lvl;
        r_tgt      <= n_tgt;
        r_found    <= n_found;
        r_off      <= n_off;
        r_mask     <= n_mask;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
        if (out_load) begin
            r_out_addr <= r_res_addr;
            r_out_st   <= r_res_st;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_addr = r_out_addr;
    assign o_rsp.status      = r_out_st;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
`include "buddy_block_allocator_assert.svh"

    `BBA_ASSERT_NEXT(a_accept_starts_work, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state != S_IDLE, "accepted item did not start work")
    `BBA_ASSERT_NOW(a_error_has_null_addr, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != bba_pkg::STAT_OK), o_rsp.result_addr == '0, "failed item carries an address")
    `BBA_ASSERT_NOW(a_idle_no_write, i_clk, i_rst_n, (r_state == S_IDLE) && !r_clr, !node_we && !leaf_we, "memory written while idle")

endmodule

`default_nettype wire
